/* rtl/ifla_pkg.sv */
// Shared types and constants for the identifier free-list allocator.
// No dependencies.
`default_nettype none
package ifla_pkg;

  localparam int CAPACITY = 64;
  localparam int ID_W     = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  // signed distance: -(CAPACITY-1) .. CAPACITY
  localparam int SKIP_W   = CNT_W + 1;

  typedef enum logic [1:0] {
    STATUS_DONE  = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_e;

  typedef enum logic {
    FUNC_ALLOC   = 1'b0,
    FUNC_RELEASE = 1'b1
  } func_e;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  typedef struct packed {
    status_e            status;
    logic [ID_W-1:0]    granted_id;
    logic [CNT_W-1:0]   live_count;
  } res_t;

  typedef struct packed {
    logic               re;
    logic [ID_W-1:0]    raddr;
    logic               we;
    logic [ID_W-1:0]    waddr;
    logic [SKIP_W-1:0]  wdata;
  } mem_req_t;

endpackage
`default_nettype wire

/* rtl/ifla_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
`default_nettype none
module ifla_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

/* rtl/ifla_ctrl.sv */
// Sequencer: head/count registers, read-modify-write of the skip table.
// Depends on ifla_pkg; drives the skip-table RAM through a request struct.
`default_nettype none
module ifla_ctrl (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic                        func_i,
  input  wire logic [ifla_pkg::ID_W-1:0]   release_id_i,
  input  wire logic                        res_room_i,
  output logic                             res_valid_o,
  output ifla_pkg::res_t                   res_o,
  output ifla_pkg::mem_req_t               mem_req_o,
  input  wire logic [ifla_pkg::SKIP_W-1:0] mem_rdata_i
);

  localparam logic [ifla_pkg::CNT_W-1:0] CapCnt = ifla_pkg::CNT_W'(ifla_pkg::CAPACITY);

  ifla_pkg::state_e                 state_q, state_d;
  logic [ifla_pkg::CNT_W-1:0]       head_q, head_d;
  logic [ifla_pkg::CNT_W-1:0]       used_q, used_d;
  logic [ifla_pkg::CAPACITY-1:0]    valid_q, valid_d;
  logic                             func_q;
  logic [ifla_pkg::ID_W-1:0]        rid_q;
  logic                             accept;
  logic                             finish;
  logic [ifla_pkg::SKIP_W-1:0]      skip;
  logic [ifla_pkg::SKIP_W-1:0]      head_sum;

  assign accept = in_valid_i && in_ready_o;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ifla_pkg::ST_IDLE: if (in_valid_i) state_d = ifla_pkg::ST_EXEC;
      ifla_pkg::ST_EXEC: if (res_room_i) state_d = ifla_pkg::ST_IDLE;
      default:           state_d = ifla_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o = 1'b0;
    finish     = 1'b0;
    unique case (state_q)
      ifla_pkg::ST_IDLE: in_ready_o = 1'b1;
      ifla_pkg::ST_EXEC: finish     = res_room_i;
      default: ;
    endcase
  end

  // entries never written read as one
  assign skip = valid_q[head_q[ifla_pkg::ID_W-1:0]] ? mem_rdata_i
                                                     : ifla_pkg::SKIP_W'(1);
  assign head_sum = ifla_pkg::SKIP_W'(head_q) + skip;

  always_comb begin
    head_d              = head_q;
    used_d              = used_q;
    valid_d             = valid_q;
    res_o.status        = ifla_pkg::STATUS_DONE;
    res_o.granted_id    = '0;
    mem_req_o.re        = accept;
    mem_req_o.raddr     = head_q[ifla_pkg::ID_W-1:0];
    mem_req_o.we        = 1'b0;
    mem_req_o.waddr     = head_q[ifla_pkg::ID_W-1:0];
    mem_req_o.wdata     = '0;
    if (func_q == ifla_pkg::FUNC_ALLOC) begin
      if (used_q >= CapCnt || head_q >= CapCnt) begin
        res_o.status = ifla_pkg::STATUS_FULL;
      end else begin
        res_o.granted_id = head_q[ifla_pkg::ID_W-1:0];
        head_d           = head_sum[ifla_pkg::CNT_W-1:0];
        used_d           = used_q + ifla_pkg::CNT_W'(1);
        mem_req_o.we     = finish;
        if (finish) valid_d[head_q[ifla_pkg::ID_W-1:0]] = 1'b1;
      end
    end else begin
      if (used_q == '0) begin
        res_o.status = ifla_pkg::STATUS_EMPTY;
      end else begin
        mem_req_o.waddr = rid_q;
        mem_req_o.wdata = ifla_pkg::SKIP_W'(head_q) - ifla_pkg::SKIP_W'(rid_q);
        mem_req_o.we    = finish;
        head_d          = ifla_pkg::CNT_W'(rid_q);
        used_d          = used_q - ifla_pkg::CNT_W'(1);
        if (finish) valid_d[rid_q] = 1'b1;
      end
    end
    res_o.live_count = used_d;
  end

  assign res_valid_o = finish;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ifla_pkg::ST_IDLE;
      head_q  <= '0;
      used_q  <= '0;
      valid_q <= '0;
    end else begin
      state_q <= state_d;
      if (finish) begin
        head_q  <= head_d;
        used_q  <= used_d;
        valid_q <= valid_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q <= func_i;
      rid_q  <= release_id_i;
    end
  end

endmodule
`default_nettype wire

/* rtl/id_free_list_allocator.sv */
// Top level of the identifier free-list allocator: stream ports, result register.
// Depends on ifla_pkg, ifla_ram, ifla_ctrl.
//
//  channel   dir  beat fields (low bit first)
//  s_axis    in   tuser: func; tdata: release_id[5:0], pad[7:6]
//  m_axis    out  tdata: status[1:0], granted_id[7:2], live_count[14:8], pad[15]
//
// Each beat runs in two steps, the idle state and the update state: the first reads
// the head slot's skip from the table RAM, the second updates the head and writes the entry back.
// The result register frees the input side while a result waits.
// Reset leaves the list in order 0, 1, 2, ...; per-entry valid flops stand in
// for the all-ones table, so there is no clearing pass.
// A stalled result holds the sequencer in its update cycle.
`default_nettype none
module id_free_list_allocator (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // release_id[5:0], zero[7:6]
  input  wire logic        s_axis_tuser_i,   // func
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [15:0]      m_axis_tdata_o    // status, granted_id, live_count, zero
);

  logic                             m_valid_q;
  ifla_pkg::res_t                   m_res_q;
  logic                             res_valid;
  logic                             res_room;
  ifla_pkg::res_t                   res;
  ifla_pkg::mem_req_t               mem_req;
  logic [ifla_pkg::SKIP_W-1:0]      mem_rdata;

  assign res_room = !m_valid_q || m_axis_tready_i;

  ifla_ram #(
    .WIDTH(ifla_pkg::SKIP_W),
    .DEPTH(ifla_pkg::CAPACITY)
  ) u_skip_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wdata),
    .re_i    (mem_req.re),
    .raddr_i (mem_req.raddr),
    .rdata_o (mem_rdata)
  );

  ifla_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .func_i       (s_axis_tuser_i),
    .release_id_i (s_axis_tdata_i[ifla_pkg::ID_W-1:0]),
    .res_room_i   (res_room),
    .res_valid_o  (res_valid),
    .res_o        (res),
    .mem_req_o    (mem_req),
    .mem_rdata_i  (mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (res_room) begin
      m_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_room && res_valid) begin
      m_res_q <= res;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {1'b0, m_res_q.live_count, m_res_q.granted_id,
                            m_res_q.status};

endmodule
`default_nettype wire

/* rtl/ifla_chk.sv */
// Port-level checker for id_free_list_allocator, bound to the top level.
// Depends on ifla_pkg.
`default_nettype none
module ifla_chk (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid_i,
  input wire logic        s_axis_tready_o,
  input wire logic [7:0]  s_axis_tdata_i,
  input wire logic        s_axis_tuser_i,
  input wire logic        m_axis_tvalid_o,
  input wire logic        m_axis_tready_i,
  input wire logic [15:0] m_axis_tdata_o
);

  localparam logic [6:0] CapCnt = 7'(ifla_pkg::CAPACITY);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o))
    else $error("result beat changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input taken during update cycle");

  a_grant_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[1:0] != ifla_pkg::STATUS_DONE
      |-> m_axis_tdata_o[7:2] == '0)
    else $error("refused beat carries an id");

  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[1:0] == ifla_pkg::STATUS_EMPTY
      |-> m_axis_tdata_o[14:8] == '0)
    else $error("empty refusal with live ids");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[14:8] <= CapCnt)
    else $error("live count above capacity");

endmodule

bind id_free_list_allocator ifla_chk u_ifla_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tdata_i  (s_axis_tdata_i),
  .s_axis_tuser_i  (s_axis_tuser_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);
`default_nettype wire
